### hw/rtl/sfcc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfcc_pkg: sensor frame crc checker definitions
// Frame positions, CRC-16 constants and the one-byte CRC update function.
// ----------------------------------------------------------------------------
package sfcc_pkg;

    localparam int POS_W    = 4;
    localparam int CRC_W    = 16;
    localparam int VAL_W    = 16;
    localparam int SCALED_W = 23;

    typedef logic [POS_W-1:0] pos_t;
    typedef logic [CRC_W-1:0] crc_t;

    localparam crc_t CRC_INIT = 16'hFFFF;
    localparam crc_t CRC_POLY = 16'hA001;

    localparam logic [VAL_W-1:0]    RESET_VALUE = 16'd9999;
    localparam logic [SCALED_W-1:0] SCALE       = 23'd100;

    // byte positions within the reply frame
    localparam pos_t POS_FIRST  = 4'd0;
    localparam pos_t POS_HUM_HI = 4'd2;
    localparam pos_t POS_HUM_LO = 4'd3;
    localparam pos_t POS_TMP_HI = 4'd4;
    localparam pos_t POS_TMP_LO = 4'd5;
    localparam pos_t CRC_BYTES  = 4'd6;
    localparam pos_t POS_CRC_LO = 4'd6;
    localparam pos_t POS_CRC_HI = 4'd7;
    localparam pos_t FRAME_DONE = 4'd8;

    // modbus crc-16, lsb first, eight shift steps per byte
    function automatic crc_t crc_update(input crc_t crc, input logic [7:0] b);
        crc_t c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/sensor_frame_crc_checker_unit.sv
`default_nettype none
// a result is registered in the middle stage, then in the output stage, after the last frame byte is accepted
// throughput: one byte per cycle while the input is not stalled, set by the single-byte crc update at the input
// output and middle stage each hold one result; input stalls only when both are full
// reset: no frame in progress, crc FFFF, stored values 9999, measured clear
// ----------------------------------------------------------------------------
// sensor_frame_crc_checker_unit
// Checks an 8-byte sensor reply with modbus crc-16 and reports scaled values.
// ----------------------------------------------------------------------------
module sensor_frame_crc_checker_unit (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            rx_byte,
    input  wire logic                  frame_start,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [22:0]         temperature_scaled,
    output logic [22:0]                humidity_scaled,
    output logic                       crc_ok,
    output logic                       measured
);

    // frame state
    sfcc_pkg::pos_t  pos_reg, pos_next;
    sfcc_pkg::crc_t  crc_reg, crc_next;
    logic [15:0]     hum_sh_reg, hum_sh_next;
    logic [15:0]     tmp_sh_reg, tmp_sh_next;
    logic [7:0]      crc_lo_reg, crc_lo_next;
    logic [15:0]     st_tmp_reg, st_tmp_next;
    logic [15:0]     st_hum_reg, st_hum_next;
    logic            meas_reg, meas_next;

    // middle stage
    logic            s1_valid_reg;
    logic [15:0]     s1_tmp_reg, s1_hum_reg;
    logic            s1_ok_reg, s1_meas_reg;

    // output stage
    logic            s2_valid_reg;
    logic [22:0]     s2_tmp_reg, s2_hum_reg;
    logic            s2_ok_reg, s2_meas_reg;

    logic            in_acc, s1_adv, s2_free;
    sfcc_pkg::pos_t  pos_eff;
    sfcc_pkg::crc_t  crc_eff;
    logic            meas_eff, frame_ok, emit;
    logic [22:0]     tmp_prod, hum_prod;

    assign s2_free = !s2_valid_reg || out_ready;
    assign s1_adv  = s1_valid_reg && s2_free;
    assign in_ready = !s1_valid_reg || s2_free;
    assign in_acc  = in_valid && in_ready;

    always_comb
    begin
        pos_eff  = frame_start ? sfcc_pkg::POS_FIRST : pos_reg;
        crc_eff  = frame_start ? sfcc_pkg::CRC_INIT : crc_reg;
        meas_eff = frame_start ? 1'b0 : meas_reg;

        pos_next    = pos_reg;
        crc_next    = crc_reg;
        hum_sh_next = hum_sh_reg;
        tmp_sh_next = tmp_sh_reg;
        crc_lo_next = crc_lo_reg;
        st_tmp_next = st_tmp_reg;
        st_hum_next = st_hum_reg;
        meas_next   = meas_reg;
        frame_ok    = (crc_eff == {rx_byte, crc_lo_reg});
        emit        = 1'b0;

        // idle bytes without a start leave everything untouched
        if (pos_eff < sfcc_pkg::FRAME_DONE) begin
            meas_next = meas_eff;
            crc_next  = (pos_eff < sfcc_pkg::CRC_BYTES)
                        ? sfcc_pkg::crc_update(crc_eff, rx_byte) : crc_eff;
            pos_next  = pos_eff + 4'd1;
            unique case (pos_eff)
                sfcc_pkg::POS_HUM_HI: hum_sh_next = {rx_byte, hum_sh_reg[7:0]};
                sfcc_pkg::POS_HUM_LO: hum_sh_next = {hum_sh_reg[15:8], rx_byte};
                sfcc_pkg::POS_TMP_HI: tmp_sh_next = {rx_byte, tmp_sh_reg[7:0]};
                sfcc_pkg::POS_TMP_LO: tmp_sh_next = {tmp_sh_reg[15:8], rx_byte};
                sfcc_pkg::POS_CRC_LO: crc_lo_next = rx_byte;
                sfcc_pkg::POS_CRC_HI:
                begin
                    emit     = 1'b1;
                    pos_next = sfcc_pkg::FRAME_DONE;
                    if (frame_ok) begin
                        st_tmp_next = tmp_sh_reg;
                        st_hum_next = hum_sh_reg;
                        meas_next   = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign tmp_prod = 23'($signed({{7{s1_tmp_reg[15]}}, s1_tmp_reg})
                          * $signed(sfcc_pkg::SCALE));
    assign hum_prod = 23'({7'b0, s1_hum_reg} * sfcc_pkg::SCALE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg      <= sfcc_pkg::FRAME_DONE;
            crc_reg      <= sfcc_pkg::CRC_INIT;
            hum_sh_reg   <= '0;
            tmp_sh_reg   <= '0;
            crc_lo_reg   <= '0;
            st_tmp_reg   <= sfcc_pkg::RESET_VALUE;
            st_hum_reg   <= sfcc_pkg::RESET_VALUE;
            meas_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (in_acc) begin
                pos_reg    <= pos_next;
                crc_reg    <= crc_next;
                hum_sh_reg <= hum_sh_next;
                tmp_sh_reg <= tmp_sh_next;
                crc_lo_reg <= crc_lo_next;
                st_tmp_reg <= st_tmp_next;
                st_hum_reg <= st_hum_next;
                meas_reg   <= meas_next;
            end
            if (in_ready) begin
                s1_valid_reg <= in_acc && emit;
            end
            if (s2_free) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_acc && emit) begin
            s1_tmp_reg  <= st_tmp_next;
            s1_hum_reg  <= st_hum_next;
            s1_ok_reg   <= frame_ok;
            s1_meas_reg <= meas_next;
        end
        if (s1_adv) begin
            s2_tmp_reg  <= tmp_prod;
            s2_hum_reg  <= hum_prod;
            s2_ok_reg   <= s1_ok_reg;
            s2_meas_reg <= s1_meas_reg;
        end
    end

    assign out_valid          = s2_valid_reg;
    assign temperature_scaled = $signed(s2_tmp_reg);
    assign humidity_scaled    = s2_hum_reg;
    assign crc_ok             = s2_ok_reg;
    assign measured           = s2_meas_reg;

    // empty middle stage never stalls the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input stalled with empty middle stage");

    // a matched crc always reports a held measurement
    a_ok_implies_measured: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && crc_ok |-> measured)
        else $error("crc match without measured flag");

    // frame position never leaves its range
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= sfcc_pkg::FRAME_DONE)
        else $error("frame position out of range");

    // a start request moves the frame to its second byte
    a_start_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && frame_start |=> pos_reg == 4'd1)
        else $error("frame start did not restart the count");

    // bytes outside a frame change no position
    a_idle_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !frame_start && pos_reg == sfcc_pkg::FRAME_DONE
        |=> pos_reg == sfcc_pkg::FRAME_DONE)
        else $error("idle byte changed frame position");

endmodule
`default_nettype wire
